/* design/edfss_pkg.sv */
// shared types and constants for the edf slice scheduler
// used by edf_slice_scheduler_top, the checker and the testbench; no dependencies
package edfss_pkg;

    localparam int TABLE_DEPTH_DEF = 8;
    localparam int SLICE_W         = 16;
    localparam int COUNT_W         = 4;
    localparam int INDEX_W         = 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [SLICE_W-1:0] SLICE_MAX = {SLICE_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

/* design/edfss_ram.sv */
// generic single write port, single read port ram with registered read data
// depends on nothing
module edfss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/edf_slice_scheduler_top.sv */
// earliest-deadline-first slice scheduler, top level
// depends on edfss_pkg and edfss_ram
//
// A load item (operation 0) writes one task entry and busy never rises for
// it. A tick item (operation 1) scans entries 0 up to task_count-1 (capped
// at TABLE_DEPTH), reading one entry per cycle from the task tables through
// a single compare unit, then writes back the decremented work of the pick,
// if there is one. Busy stays high for the whole tick, so no new item is
// accepted until it falls; the result appears with o_done in the first cycle
// that busy is low. o_done is high for exactly one cycle and the result cannot
// be held off. task_count is written through the cfg channel, whose ready is
// high while the block is not busy. The task tables have no reset: every entry
// below task_count must be loaded before a tick.
module edf_slice_scheduler_top #(
    parameter int TABLE_DEPTH = edfss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [edfss_pkg::INDEX_W-1:0] i_entry_index,
    input  logic [edfss_pkg::SLICE_W-1:0] i_arrival_slice,
    input  logic [edfss_pkg::SLICE_W-1:0] i_deadline_slice,
    input  logic [edfss_pkg::SLICE_W-1:0] i_work_slices,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [edfss_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                          o_done,
    output logic                          o_chosen_valid,
    output logic [edfss_pkg::INDEX_W-1:0] o_chosen_task,
    output logic [edfss_pkg::SLICE_W-1:0] o_slice_time,
    output logic [edfss_pkg::SLICE_W-1:0] o_work_left
);

    import edfss_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // wide enough for the entry index, task_count and the table depth itself
    localparam int CW = AW + COUNT_W + 1;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_task_count;
    logic [SLICE_W-1:0] r_slice;
    logic [SLICE_W-1:0] r_now;
    logic [CW-1:0]      r_limit;
    logic [CW-1:0]      r_scan;
    logic               r_rd_valid;
    logic [AW-1:0]      r_rd_idx;
    logic               r_found;
    logic [SLICE_W-1:0] r_best_dl;
    logic [SLICE_W-1:0] r_best_rem;
    logic [AW-1:0]      r_pick;
    logic               r_done;
    logic               r_chosen_valid;
    logic [INDEX_W-1:0] r_chosen_task;
    logic [SLICE_W-1:0] r_slice_time;
    logic [SLICE_W-1:0] r_work_left;

    logic accept;
    logic accept_load;
    logic accept_tick;
    logic scan_issue;
    logic finish;
    logic load_in_range;
    logic [CW-1:0] entry_ext;
    logic [CW-1:0] count_ext;
    logic [CW-1:0] limit_in;
    logic [CW-1:0] pick_ext;

    logic                 ent_we;
    logic [2*SLICE_W-1:0] ent_rdata;
    logic                 rem_we;
    logic [AW-1:0]        rem_waddr;
    logic [SLICE_W-1:0]   rem_wdata;
    logic [SLICE_W-1:0]   rem_rdata;
    logic [SLICE_W-1:0]   rd_arrival;
    logic [SLICE_W-1:0]   rd_deadline;
    logic                 better;
    logic [SLICE_W-1:0]   dec_rem;

    // fsm next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept_tick) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // the last entry is compared in this cycle, its result is registered
                if (r_scan >= r_limit) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        busy        = 1'b1;
        scan_issue  = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_SCAN:   scan_issue = (r_scan < r_limit);
            ST_FINISH: finish = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

    assign accept      = start && !busy;
    assign accept_load = accept && (i_operation == OP_LOAD);
    assign accept_tick = accept && (i_operation == OP_TICK);
    assign o_cfg_ready = !busy;

    assign entry_ext     = CW'(i_entry_index);
    assign load_in_range = (entry_ext < CW'(TABLE_DEPTH));
    assign count_ext     = CW'(r_task_count);
    assign limit_in      = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;

    // tables: arrival and deadline together, remaining work on its own
    assign ent_we = accept_load && load_in_range;

    edfss_ram #(
        .WIDTH (2*SLICE_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (entry_ext[AW-1:0]),
        .i_wdata ({i_arrival_slice, i_deadline_slice}),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (ent_rdata)
    );

    assign dec_rem   = r_best_rem - SLICE_W'(1);
    assign rem_we    = ent_we || (finish && r_found);
    assign rem_waddr = finish ? r_pick : entry_ext[AW-1:0];
    assign rem_wdata = finish ? dec_rem : i_work_slices;

    edfss_ram #(
        .WIDTH (SLICE_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (rem_waddr),
        .i_wdata (rem_wdata),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (rem_rdata)
    );

    assign rd_arrival  = ent_rdata[2*SLICE_W-1:SLICE_W];
    assign rd_deadline = ent_rdata[SLICE_W-1:0];

    // the shared compare: eligible and strictly earlier keeps lowest index on ties
    assign better = (rd_arrival <= r_now) && (rem_rdata != '0)
                    && (!r_found || rd_deadline < r_best_dl);

    assign pick_ext = CW'(r_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_task_count <= '0;
            r_slice      <= '0;
            r_rd_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= scan_issue;
            r_done     <= finish;
            if (i_cfg_valid && o_cfg_ready) begin
                r_task_count <= i_cfg_data;
            end
            if (accept_tick) begin
                r_found <= 1'b0;
            end else if (r_rd_valid && better) begin
                r_found <= 1'b1;
            end
            if (finish && r_slice != SLICE_MAX) begin
                r_slice <= r_slice + SLICE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_tick) begin
            r_now   <= r_slice;
            r_limit <= limit_in;
            r_scan  <= '0;
        end else if (scan_issue) begin
            r_scan <= r_scan + CW'(1);
        end
        r_rd_idx <= r_scan[AW-1:0];
        if (r_rd_valid && better) begin
            r_best_dl  <= rd_deadline;
            r_best_rem <= rem_rdata;
            r_pick     <= r_rd_idx;
        end
        if (finish) begin
            r_chosen_valid <= r_found;
            r_chosen_task  <= r_found ? pick_ext[INDEX_W-1:0] : '0;
            r_slice_time   <= r_now;
            r_work_left    <= r_found ? dec_rem : '0;
        end
    end

    assign o_done         = r_done;
    assign o_chosen_valid = r_chosen_valid;
    assign o_chosen_task  = r_chosen_task;
    assign o_slice_time   = r_slice_time;
    assign o_work_left    = r_work_left;

`ifndef NO_ASSERTIONS
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_FINISH))
        else $error("result strobe without a finished scan");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_chosen_valid) |-> (o_chosen_task == '0 && o_work_left == '0))
        else $error("idle result carries nonzero task fields");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan <= r_limit))
        else $error("scan index ran past the task limit");

    a_slice_moves_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_slice) |-> $past(r_state == ST_FINISH))
        else $error("slice counter changed outside a tick");
`endif

endmodule

/* tb/sv/edf_slice_scheduler_checker.sv */
// checker for the edf slice scheduler: tracks task table, slice counter and task_count,
// predicts each tick pick and compares it against o_done results; depends on edfss_pkg
module edf_slice_scheduler_checker
    import edfss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_operation,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [SLICE_W-1:0] i_arrival_slice,
    input  logic [SLICE_W-1:0] i_deadline_slice,
    input  logic [SLICE_W-1:0] i_work_slices,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_done,
    input  logic               i_chosen_valid,
    input  logic [INDEX_W-1:0] i_chosen_task,
    input  logic [SLICE_W-1:0] i_slice_time,
    input  logic [SLICE_W-1:0] i_work_left,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               picked;
        logic [INDEX_W-1:0] idx;
        logic [SLICE_W-1:0] at_slice;
        logic [SLICE_W-1:0] left;
    } slice_pick_t;

    logic [SLICE_W-1:0] arrival_tab  [TABLE_DEPTH_DEF];
    logic [SLICE_W-1:0] deadline_tab [TABLE_DEPTH_DEF];
    logic [SLICE_W-1:0] work_tab     [TABLE_DEPTH_DEF];
    logic [SLICE_W-1:0] now_slice;
    logic [COUNT_W-1:0] task_count;
    slice_pick_t        expected_picks[$];
    int                 fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // earliest deadline among arrived entries with work left, lowest index on a tie
    function automatic slice_pick_t pick_earliest_deadline();
        slice_pick_t        p;
        int                 scan_len;
        int                 pick_i;
        logic [SLICE_W-1:0] best;
        p.picked   = 1'b0;
        p.idx      = '0;
        p.at_slice = now_slice;
        p.left     = '0;
        pick_i     = 0;
        best       = '0;
        scan_len   = (task_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(task_count);
        for (int i = 0; i < scan_len; i++) begin
            if (arrival_tab[i] <= now_slice && work_tab[i] != '0) begin
                if (!p.picked || deadline_tab[i] < best) begin
                    p.picked = 1'b1;
                    best     = deadline_tab[i];
                    pick_i   = i;
                end
            end
        end
        if (p.picked) begin
            work_tab[pick_i] = work_tab[pick_i] - 1'b1;
            p.idx            = INDEX_W'(pick_i);
            p.left           = work_tab[pick_i];
        end
        if (now_slice != SLICE_MAX) begin
            now_slice = now_slice + 1'b1;
        end
        return p;
    endfunction

    task automatic check_field(input string name, input logic [SLICE_W-1:0] exp_v,
                               input logic [SLICE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        slice_pick_t exp_p;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
                arrival_tab[i]  = '0;
                deadline_tab[i] = '0;
                work_tab[i]     = '0;
            end
            now_slice  = '0;
            task_count = '0;
            expected_picks.delete();
        end else begin
            // results leave before a tick accepted on this same edge can add one
            if (i_done) begin
                if (expected_picks.size() == 0) begin
                    $error("result with no tick waiting: task %0d, slice %0d",
                           i_chosen_task, i_slice_time);
                    fail_count++;
                end else begin
                    exp_p = expected_picks.pop_front();
                    check_field("chosen_valid", SLICE_W'(exp_p.picked), SLICE_W'(i_chosen_valid));
                    check_field("chosen_task", SLICE_W'(exp_p.idx), SLICE_W'(i_chosen_task));
                    check_field("slice_time", exp_p.at_slice, i_slice_time);
                    check_field("work_left", exp_p.left, i_work_left);
                end
            end
            if (i_start && !i_busy) begin
                if (i_operation == OP_TICK) begin
                    expected_picks.push_back(pick_earliest_deadline());
                end else if (i_entry_index < TABLE_DEPTH_DEF) begin
                    arrival_tab[i_entry_index]  = i_arrival_slice;
                    deadline_tab[i_entry_index] = i_deadline_slice;
                    work_tab[i_entry_index]     = i_work_slices;
                end
            end
            // a tick on the same edge still scans with the old count
            if (i_cfg_valid && i_cfg_ready) begin
                task_count = i_cfg_data;
            end
        end
        o_pending    <= expected_picks.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/sv/edf_slice_scheduler_top_tb.sv */
// testbench top for edf_slice_scheduler_top: clock, reset, load/tick items and task_count writes
// depends on edfss_pkg, edf_slice_scheduler_top and edf_slice_scheduler_checker
module edf_slice_scheduler_top_tb;
    import edfss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int IDLE_SETTLE = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_operation = OP_LOAD;
    logic [INDEX_W-1:0] i_entry_index = '0;
    logic [SLICE_W-1:0] i_arrival_slice = '0;
    logic [SLICE_W-1:0] i_deadline_slice = '0;
    logic [SLICE_W-1:0] i_work_slices = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;
    logic               o_done;
    logic               o_chosen_valid;
    logic [INDEX_W-1:0] o_chosen_task;
    logic [SLICE_W-1:0] o_slice_time;
    logic [SLICE_W-1:0] o_work_left;
    int                 fail_count;
    int                 pending;

    int cycle_count = 0;
    int sent_slice = 0;     // slice counter as the block should see it
    int burst_left = 0;
    int phase_counts[12] = '{8, 1, 15, 3, 0, 6, 9, 8, 2, 5, 7, 4};

    edf_slice_scheduler_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .i_arrival_slice (i_arrival_slice),
        .i_deadline_slice(i_deadline_slice),
        .i_work_slices   (i_work_slices),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_chosen_valid  (o_chosen_valid),
        .o_chosen_task   (o_chosen_task),
        .o_slice_time    (o_slice_time),
        .o_work_left     (o_work_left)
    );

    edf_slice_scheduler_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .i_arrival_slice (i_arrival_slice),
        .i_deadline_slice(i_deadline_slice),
        .i_work_slices   (i_work_slices),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_done          (o_done),
        .i_chosen_valid  (o_chosen_valid),
        .i_chosen_task   (o_chosen_task),
        .i_slice_time    (o_slice_time),
        .i_work_left     (o_work_left),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("edf_slice_scheduler_top_tb: errors");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic op_v, input logic [INDEX_W-1:0] idx_v,
                             input logic [SLICE_W-1:0] arr_v, input logic [SLICE_W-1:0] dl_v,
                             input logic [SLICE_W-1:0] work_v);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(1, 8);
        end
        start            = 1'b1;
        i_operation      = op_v;
        i_entry_index    = idx_v;
        i_arrival_slice  = arr_v;
        i_deadline_slice = dl_v;
        i_work_slices    = work_v;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        burst_left--;
        if (op_v == OP_TICK && sent_slice < int'(SLICE_MAX))
            sent_slice++;
    endtask

    task automatic tick();
        send_item(OP_TICK, INDEX_W'($urandom), SLICE_W'($urandom), SLICE_W'($urandom),
                  SLICE_W'($urandom));
    endtask

    // drain all tick results, then let a trailing load settle before touching config
    task automatic write_task_count(input logic [COUNT_W-1:0] count_v);
        start = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (IDLE_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = count_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = COUNT_W'($urandom);
    endtask

    function automatic logic [SLICE_W-1:0] near_slice(input int back, input int fwd);
        int v;
        v = sent_slice - back + int'($urandom_range(0, back + fwd));
        if (v < 0) v = 0;
        if (v > int'(SLICE_MAX)) v = int'(SLICE_MAX);
        return SLICE_W'(v);
    endfunction

    // loads are mostly shaped around the current slice so entries compete
    task automatic random_item();
        logic [SLICE_W-1:0] arr_v;
        logic [SLICE_W-1:0] dl_v;
        logic [SLICE_W-1:0] work_v;
        int                 sel;
        if ($urandom_range(0, 99) < 55) begin
            tick();
        end else begin
            arr_v = ($urandom_range(0, 9) < 7) ? near_slice(30, 10) : SLICE_W'($urandom);
            sel = $urandom_range(0, 9);
            if (sel == 0)      dl_v = SLICE_MAX;
            else if (sel == 1) dl_v = '0;
            else if (sel < 4)  dl_v = near_slice(0, 3);
            else if (sel < 9)  dl_v = near_slice(5, 80);
            else               dl_v = SLICE_W'($urandom);
            sel = $urandom_range(0, 9);
            if (sel == 0)      work_v = '0;
            else if (sel == 1) work_v = SLICE_MAX;
            else if (sel == 2) work_v = SLICE_W'($urandom);
            else               work_v = SLICE_W'($urandom_range(1, 6));
            send_item(OP_LOAD, INDEX_W'($urandom), arr_v, dl_v, work_v);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no entries take part yet: idle at slice 0
        tick();
        send_item(OP_LOAD, 3'd0, 16'd0, 16'hFFFF, 16'd1);
        send_item(OP_LOAD, 3'd1, 16'd0, 16'd10, 16'd2);
        send_item(OP_LOAD, 3'd2, 16'd0, 16'd10, 16'd3);
        send_item(OP_LOAD, 3'd3, 16'hFFFF, 16'd0, 16'hFFFF);
        send_item(OP_LOAD, 3'd4, 16'd2, 16'd5, 16'd1);
        send_item(OP_LOAD, 3'd5, 16'd0, 16'd0, 16'd0);
        send_item(OP_LOAD, 3'd6, 16'd1, 16'd20, 16'd1);
        send_item(OP_LOAD, 3'd7, 16'd0, 16'hFFFF, 16'hFFFF);
        // count past the table depth, then tie, arrival and max-deadline picks
        write_task_count(4'd15);
        repeat (6) tick();
        write_task_count(4'd1);
        repeat (2) tick();
        // entry 0 out of work: nothing eligible
        send_item(OP_LOAD, 3'd0, 16'd0, 16'd0, 16'd0);
        tick();

        foreach (phase_counts[p]) begin
            write_task_count(COUNT_W'(phase_counts[p]));
            repeat (88) random_item();
        end

        start = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (pending != 0)
            $error("%0d tick results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("edf_slice_scheduler_top_tb: clean");
        else
            $display("edf_slice_scheduler_top_tb: errors");
        $finish;
    end

endmodule

/* edf_slice_scheduler_top.f */
design/edfss_pkg.sv
design/edfss_ram.sv
design/edf_slice_scheduler_top.sv
tb/sv/edf_slice_scheduler_checker.sv
tb/sv/edf_slice_scheduler_top_tb.sv
